### rtl/core/sha256s_pkg.sv
// sha256s_pkg: shared types, round constants and sigma functions of the stream hasher
// used by every module under rtl/core; depends on nothing
`default_nettype none

package sha256s_pkg;

	localparam int unsigned NUM_WORDS = 8;

	typedef logic [NUM_WORDS-1:0][31:0] hash_arr_t;

	// request from the sequencer to the window and round datapath
	typedef struct packed {
		logic       load;       // shift one byte into the message window
		logic [7:0] load_byte;
		logic       start;      // copy hash words into the working variables
		logic       round_en;   // run one compression round
		logic [5:0] rnd;
		logic       add_en;     // fold working variables into the hash words
		logic       init;       // reload the initial hash values
	} ctl_t;

	localparam logic [31:0] H_INIT [NUM_WORDS] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] K_ROUND [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
		input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

### rtl/core/sha256s_in_if.sv
// sha256s_in_if: message byte channel, valid/ready with byte, byte flag and end flag
// no dependencies
`default_nettype none

interface sha256s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte, output end_of_message,
		input ready);
	modport sink (input valid, input data_byte, input has_byte, input end_of_message,
		output ready);
endinterface

`default_nettype wire

### rtl/core/sha256s_out_if.sv
// sha256s_out_if: digest word channel, valid/ready with word, index and last flag
// no dependencies
`default_nettype none

interface sha256s_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

`default_nettype wire

### rtl/core/sha256s_sched.sv
// sha256s_sched: 16-word message window, filled a byte at a time, then run as the
// message schedule shift line; depends on sha256s_pkg
`default_nettype none

module sha256s_sched (
	input  wire                      clk,
	input  wire sha256s_pkg::ctl_t   ctl,
	output logic [31:0]              w
);

	logic [31:0] win_q [16];

	// first 16 rounds take the loaded words, later ones extend the schedule
	always_comb begin
		if (ctl.rnd < 6'd16) begin
			w = win_q[0];
		end else begin
			w = sha256s_pkg::ssig1(win_q[14]) + win_q[9] + sha256s_pkg::ssig0(win_q[1])
				+ win_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ctl.load_byte};
		end else if (ctl.round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sha256s_round.sv
// sha256s_round: working variables, hash words and the shared round unit
// depends on sha256s_pkg
`default_nettype none

module sha256s_round (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire sha256s_pkg::ctl_t  ctl,
	input  wire [31:0]              w,
	output sha256s_pkg::hash_arr_t  hash
);

	logic [31:0] hash_q [8];
	logic [31:0] work_q [8];
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		t1 = work_q[7] + sha256s_pkg::bsig1(work_q[4])
			+ sha256s_pkg::ch(work_q[4], work_q[5], work_q[6])
			+ sha256s_pkg::K_ROUND[ctl.rnd] + w;
		t2 = sha256s_pkg::bsig0(work_q[0]) + sha256s_pkg::maj(work_q[0], work_q[1], work_q[2]);
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hash[i] = hash_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha256s_pkg::H_INIT[i];
			end
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha256s_pkg::H_INIT[i];
			end
		end else if (ctl.add_en) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= hash_q[i];
			end
		end else if (ctl.round_en) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sha256s_ctrl.sv
// sha256s_ctrl: sequencer for byte loading, padding, rounds and digest output
// depends on sha256s_pkg
`default_nettype none

module sha256s_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                msg_valid,
	input  wire [7:0]          data_byte,
	input  wire                has_byte,
	input  wire                end_of_message,
	output logic               msg_ready,
	output logic               dig_valid,
	input  wire                dig_ready,
	output logic [2:0]         idx,
	output sha256s_pkg::ctl_t  ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_ROUND = 3'd2;
	localparam logic [2:0] S_ADD   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	localparam logic [5:0] LEN_POS_C = sha256s_pkg::LEN_POS;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [63:0] len_q;
	logic        mark_q;
	logic        lenok_q;
	logic        pad_q;
	logic        fin_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;

	logic       acc_in;
	logic       acc_out;
	logic       lenok_now;
	logic       go_round;
	logic [7:0] pad_byte;

	always_comb begin
		acc_in    = msg_valid && (state_q == S_IDLE);
		acc_out   = dig_ready && (state_q == S_EMIT);
		// marker decides whether the length still fits in this block
		lenok_now = mark_q ? (fill_q < LEN_POS_C) : lenok_q;
		if (mark_q) begin
			pad_byte = sha256s_pkg::PAD_MARK;
		end else if (lenok_q && fill_q >= LEN_POS_C) begin
			pad_byte = len_q[63:56];
		end else begin
			pad_byte = 8'h00;
		end

		ctl.load      = (acc_in && has_byte) || (state_q == S_PAD);
		ctl.load_byte = (state_q == S_PAD) ? pad_byte : data_byte;
		ctl.start     = ctl.load && (fill_q == 6'd63);
		ctl.round_en  = (state_q == S_ROUND);
		ctl.rnd       = rnd_q;
		ctl.add_en    = (state_q == S_ADD);
		ctl.init      = acc_out && (idx_q == 3'd7);
		go_round      = ctl.start;

		msg_ready = (state_q == S_IDLE);
		dig_valid = (state_q == S_EMIT);
		idx       = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			count_q <= '0;
			len_q   <= '0;
			mark_q  <= 1'b0;
			lenok_q <= 1'b0;
			pad_q   <= 1'b0;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (ctl.load) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						pad_q  <= end_of_message;
						mark_q <= 1'b1;
						fin_q  <= 1'b0;
						if (has_byte) begin
							count_q <= count_q + 61'd1;
						end
						if (go_round) begin
							rnd_q   <= '0;
							state_q <= S_ROUND;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					mark_q  <= 1'b0;
					lenok_q <= lenok_now;
					if (mark_q) begin
						len_q <= {count_q, 3'b000};
					end else if (lenok_q && fill_q >= LEN_POS_C) begin
						len_q <= {len_q[55:0], 8'h00};
					end
					if (go_round) begin
						fin_q   <= lenok_now;
						rnd_q   <= '0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					if (fin_q) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else if (pad_q) begin
						// length goes into the extra block
						lenok_q <= 1'b1;
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (acc_out) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							fill_q  <= '0;
							count_q <= '0;
							pad_q   <= 1'b0;
							fin_q   <= 1'b0;
							lenok_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/sha256_stream_hasher.sv
// sha256_stream_hasher: SHA-256 over a byte stream, digest out as eight words
// depends on sha256s_pkg, sha256s_in_if, sha256s_out_if, sha256s_ctrl, sha256s_sched,
// sha256s_round
//
// msg carries one request per byte (has_byte) and may flag the end of the message
// (end_of_message, with or without a byte). dig returns the digest as eight 32-bit
// words, most significant first, word_index 0..7, last_word on the eighth.
// The 64th byte of a block starts the compression, which holds msg.ready low
// through 64 rounds in one round unit and one hash update. End of message appends
// the marker, zeros and the bit length one byte per cycle and compresses one or two
// more blocks; at worst the marker lands at byte 56 and the length is pushed into an
// extra block, so two blocks are compressed before the first digest word.
// While digest words are offered, msg.ready stays low; a stalled dig.ready holds the
// current word. After the eighth word is taken the hash words reload their initial
// values and msg.ready returns the next cycle.
// Reset leaves the block idle and ready, with the initial hash values loaded.
`default_nettype none

module sha256_stream_hasher (
	input  wire             clk,
	input  wire             arst_n,
	sha256s_in_if.sink      msg,
	sha256s_out_if.source   dig
);

	sha256s_pkg::ctl_t       ctl;
	sha256s_pkg::hash_arr_t  hash;
	logic [31:0]             w;
	logic [2:0]              idx;

	sha256s_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg.valid),
		.data_byte      (msg.data_byte),
		.has_byte       (msg.has_byte),
		.end_of_message (msg.end_of_message),
		.msg_ready      (msg.ready),
		.dig_valid      (dig.valid),
		.dig_ready      (dig.ready),
		.idx            (idx),
		.ctl            (ctl)
	);

	sha256s_sched u_sched (
		.clk (clk),
		.ctl (ctl),
		.w   (w)
	);

	sha256s_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w      (w),
		.hash   (hash)
	);

	assign dig.digest_word = hash[idx];
	assign dig.word_index  = idx;
	assign dig.last_word   = (idx == 3'd7);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && dig.valid))
		else $error("input ready while digest words pending");

	a_ready_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(dig.valid && dig.ready && dig.last_word) |=> (msg.ready && !dig.valid))
		else $error("block not idle after last digest word");

	a_empty_request: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready && !msg.has_byte && !msg.end_of_message) |=> msg.ready)
		else $error("empty request started work");
`endif

endmodule

`default_nettype wire
